[src/ordered_list_append_delete_unit_assert.svh]
// Assertion macros shared by the ordered list unit RTL.
// Expects the including module to have i_clk and the active-low i_rst_n.
`ifndef ORDERED_LIST_APPEND_DELETE_UNIT_ASSERT_SVH
`define ORDERED_LIST_APPEND_DELETE_UNIT_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define OLAD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("olad assertion failed");

// Next-cycle implication, checked only outside reset.
`define OLAD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("olad assertion failed");

`endif

[src/olad_pkg.sv]
// Package for the ordered list unit: command and status codes, field widths.
// No dependencies.
`default_nettype none

package olad_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 5;

    typedef enum logic [1:0] {
        CMD_APPEND   = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_DUMP_FWD = 2'd2,
        CMD_DUMP_BWD = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

endpackage

`default_nettype wire

[src/olad_ram.sv]
// Entry storage of the ordered list: one write port, one registered read port.
// Depends on olad_pkg for the value width.
`default_nettype none

module olad_ram import olad_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [AW-1:0]           i_waddr,
    input  wire logic signed [VAL_W-1:0] i_wdata,
    input  wire logic [AW-1:0]           i_raddr,
    output logic signed [VAL_W-1:0]      o_rdata
);

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    // Contents are undefined until written; the sequencer only reads live entries.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/olad_seq.sv]
// Sequencer of the ordered list unit: command decode, gap-closing shift and dumps,
// one memory access step per cycle. Depends on olad_pkg and the assertion macros.
`default_nettype none
`include "ordered_list_append_delete_unit_assert.svh"

module olad_seq import olad_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [1:0]              i_cmd,
    input  wire logic signed [VAL_W-1:0] i_value,
    input  wire logic [POS_W-1:0]        i_position,
    output logic                         o_busy,
    output logic                         o_we,
    output logic [AW-1:0]                o_waddr,
    output logic signed [VAL_W-1:0]      o_wdata,
    output logic [AW-1:0]                o_raddr,
    input  wire logic signed [VAL_W-1:0] i_rdata,
    output logic                         o_strobe,
    output logic signed [VAL_W-1:0]      o_value_res,
    output logic [1:0]                   o_status,
    output logic                         o_last
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_DUMP
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_idx, n_idx;
    logic                    r_pend, n_pend;
    logic                    r_pend_last, n_pend_last;
    logic                    r_bwd, n_bwd;
    logic                    r_strobe, n_strobe;
    logic signed [VAL_W-1:0] r_value, n_value;
    t_status                 r_status, n_status;
    logic                    r_last, n_last;

    logic [CW-1:0]   w_idx_inc;
    logic [CW-1:0]   w_wr_idx;
    logic [CW-1:0]   w_bwd_idx;
    logic [CMPW-1:0] w_pos_ext;
    logic [CMPW-1:0] w_cnt_ext;
    logic            w_more;

    // Index arithmetic for the shift and dump walks.
    assign w_idx_inc = r_idx + CW'(1);
    assign w_wr_idx  = r_idx - CW'(2);
    assign w_bwd_idx = r_count - w_idx_inc;
    assign w_pos_ext = CMPW'(i_position);
    assign w_cnt_ext = CMPW'(r_count);
    assign w_more    = (r_idx < r_count);

    // Next-state and memory request logic.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_bwd       = r_bwd;
        n_strobe    = 1'b0;
        n_value     = '0;
        n_status    = ST_OK;
        n_last      = 1'b1;
        o_we        = 1'b0;
        o_waddr     = r_count[AW-1:0];
        o_wdata     = i_value;
        o_raddr     = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (t_cmd'(i_cmd))
                        CMD_APPEND: begin
                            n_strobe = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else if (w_pos_ext == '0 || w_pos_ext > w_cnt_ext) begin
                                n_strobe = 1'b1;
                                n_status = ST_BADPOS;
                            end else if (w_pos_ext == w_cnt_ext) begin
                                // Removing the tail entry needs no shift.
                                n_strobe = 1'b1;
                                n_count  = r_count - CW'(1);
                            end else begin
                                n_idx   = CW'(i_position);
                                n_pend  = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                        CMD_DUMP_FWD, CMD_DUMP_BWD: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_pend  = 1'b0;
                                n_bwd   = (t_cmd'(i_cmd) == CMD_DUMP_BWD);
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // The entry read last cycle moves down one place.
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = w_wr_idx[AW-1:0];
                    o_wdata = i_rdata;
                end
                if (w_more) begin
                    n_idx  = w_idx_inc;
                    n_pend = 1'b1;
                end else begin
                    n_count  = r_count - CW'(1);
                    n_pend   = 1'b0;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DUMP: begin
                // Emit the entry read last cycle while issuing the next read.
                if (r_pend) begin
                    n_strobe = 1'b1;
                    n_value  = i_rdata;
                    n_last   = r_pend_last;
                end
                if (w_more) begin
                    o_raddr     = r_bwd ? w_bwd_idx[AW-1:0] : r_idx[AW-1:0];
                    n_idx       = w_idx_inc;
                    n_pend      = 1'b1;
                    n_pend_last = (w_idx_inc == r_count);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered result outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_bwd       <= 1'b0;
            r_strobe    <= 1'b0;
            r_status    <= ST_OK;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_bwd       <= n_bwd;
            r_strobe    <= n_strobe;
            r_status    <= n_status;
            r_last      <= n_last;
        end
        r_value <= n_value;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_value_res = r_value;
    assign o_status    = r_status;
    assign o_last      = r_last;

    // Consistency checks on the sequencer.
    `OLAD_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(DEPTH))
    `OLAD_ASSERT_NXT(a_append_result, i_start && !o_busy && i_cmd == CMD_APPEND, r_strobe && r_last)
    `OLAD_ASSERT_IMP(a_shift_silent, r_state == S_SHIFT, !r_strobe)
    `OLAD_ASSERT_NXT(a_dump_keeps_count, r_state == S_DUMP, $stable(r_count))
    `OLAD_ASSERT_IMP(a_dump_no_write, r_state == S_DUMP, !o_we)

endmodule

`default_nettype wire

[src/ordered_list_append_delete_unit.sv]
// Top level of the ordered list unit: sequencer plus entry memory.
// Depends on olad_pkg, olad_seq and olad_ram.
//
//  Channel   | Handshake                  | Payload
//  ----------+----------------------------+-------------------------------------
//  command   | start high, busy low       | i_cmd, i_value, i_position
//  result    | o_strobe for one cycle     | o_value_res, o_status, o_last
//
// Append, a rejected delete and an empty dump leave busy low; the result
// appears the cycle after acceptance. Delete at position p of n entries holds
// busy while the entries above p move down (n = p: no move, busy low): one
// entry moves per cycle, read on the read port and written one place lower.
// A dump of n entries holds busy as it reads them, giving one result a cycle.
// Reset is synchronous, active low, and empties the list at once.
// The result side cannot stall; each result is valid for exactly one cycle.
`default_nettype none

module ordered_list_append_delete_unit import olad_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    input  wire logic [1:0]              i_cmd,
    input  wire logic signed [VAL_W-1:0] i_value,
    input  wire logic [POS_W-1:0]        i_position,
    output logic                         busy,
    output logic                         o_strobe,
    output logic signed [VAL_W-1:0]      o_value_res,
    output logic [1:0]                   o_status,
    output logic                         o_last
);

    localparam int AW = $clog2(DEPTH);

    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic signed [VAL_W-1:0] w_wdata;
    logic [AW-1:0]           w_raddr;
    logic signed [VAL_W-1:0] w_rdata;

    // Command sequencer.
    olad_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_busy      (busy),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_strobe    (o_strobe),
        .o_value_res (o_value_res),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    // Entry storage.
    olad_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule

`default_nettype wire

[dv/olad_list_checker.sv]
// Checker for the ordered list unit: predicts every result transaction and compares it.
// Depends on olad_pkg for the command and status codes and the field widths.
`default_nettype none

module olad_list_checker import olad_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic                    i_busy,
    input  wire logic [1:0]              i_cmd,
    input  wire logic signed [VAL_W-1:0] i_value,
    input  wire logic [POS_W-1:0]        i_position,
    input  wire logic                    i_strobe,
    input  wire logic signed [VAL_W-1:0] i_value_res,
    input  wire logic [1:0]              i_status,
    input  wire logic                    i_last,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct {
        logic signed [VAL_W-1:0] value;
        t_status                 status;
        logic                    last;
    } t_list_result;

    // Own copy of the list contents and its occupancy.
    logic signed [VAL_W-1:0] list_entries [DEPTH];
    int                      list_len;

    t_list_result            expected_results [$];
    int                      n_fail;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        n_fail       = 0;
        list_len     = 0;
    end

    task automatic push_result(input logic signed [VAL_W-1:0] value, input t_status status,
                               input logic last);
        t_list_result r;
        r.value  = value;
        r.status = status;
        r.last   = last;
        expected_results.push_back(r);
    endtask

    // Apply one accepted command to the list copy and queue the results it causes.
    task automatic apply_list_command(input t_cmd cmd, input logic signed [VAL_W-1:0] value,
                                      input logic [POS_W-1:0] pos);
        int idx;
        case (cmd)
            CMD_APPEND: begin
                if (list_len >= DEPTH) begin
                    push_result('0, ST_FULL, 1'b1);
                end else begin
                    list_entries[list_len] = value;
                    list_len++;
                    push_result('0, ST_OK, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (list_len == 0) begin
                    push_result('0, ST_EMPTY, 1'b1);
                end else if (pos == 0 || int'(pos) > list_len) begin
                    push_result('0, ST_BADPOS, 1'b1);
                end else begin
                    // Close the gap so the other entries keep their order.
                    for (int i = int'(pos) - 1; i + 1 < list_len; i++) begin
                        list_entries[i] = list_entries[i + 1];
                    end
                    list_len--;
                    push_result('0, ST_OK, 1'b1);
                end
            end
            default: begin
                if (list_len == 0) begin
                    push_result('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < list_len; i++) begin
                        idx = (cmd == CMD_DUMP_FWD) ? i : list_len - 1 - i;
                        push_result(list_entries[idx], ST_OK, (i + 1 == list_len));
                    end
                end
            end
        endcase
    endtask

    // Compare results first, since a result never belongs to a command accepted at the
    // same edge; then predict for the command accepted at this edge.
    always @(posedge i_clk) begin
        t_list_result exp_r;
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
        end else begin
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expectation: %s %0d %s %0d %s %0d",
                           "value_res", i_value_res, "status", i_status, "last", i_last);
                    n_fail++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_value_res !== exp_r.value) begin
                        $error("value_res: expected %0d, actual %0d", exp_r.value, i_value_res);
                        n_fail++;
                    end
                    if (i_status !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, i_status);
                        n_fail++;
                    end
                    if (i_last !== exp_r.last) begin
                        $error("last: expected %0d, actual %0d", exp_r.last, i_last);
                        n_fail++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_list_command(t_cmd'(i_cmd), i_value, i_position);
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= expected_results.size();
    end

endmodule

`default_nettype wire

[dv/tb_ordered_list_append_delete_unit.sv]
// Testbench top for the ordered list unit: clock, reset, command stimulus and verdict.
// Depends on olad_pkg, the unit itself and olad_list_checker.
`default_nettype none

module tb_ordered_list_append_delete_unit;
    import olad_pkg::*;

    localparam int DEPTH          = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 40;

    logic                    i_clk;
    logic                    i_rst_n    = 1'b0;
    logic                    start      = 1'b0;
    logic [1:0]              i_cmd      = CMD_APPEND;
    logic signed [VAL_W-1:0] i_value    = '0;
    logic [POS_W-1:0]        i_position = '0;
    wire logic               busy;
    wire logic               o_strobe;
    wire logic signed [VAL_W-1:0] o_value_res;
    wire logic [1:0]         o_status;
    wire logic               o_last;

    int fail_count;
    int pending_count;
    int list_len    = 0;
    int idle_pct    = 30;
    int stall_count = 0;

    ordered_list_append_delete_unit #(.DEPTH(DEPTH)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .i_position  (i_position),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_value_res (o_value_res),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    olad_list_checker #(.DEPTH(DEPTH)) list_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_position   (i_position),
        .i_strobe     (o_strobe),
        .i_value_res  (o_value_res),
        .i_status     (o_status),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Clock with a period of 12.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("ordered_list_append_delete_unit: mismatch");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Drop start for a burst of cycles, with noise on the idle command fields.
    task automatic pause_sender(input int n);
        start      <= 1'b0;
        i_cmd      <= 2'($urandom);
        i_value    <= $urandom;
        i_position <= 5'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    // Present one command transaction and return at the edge that accepts it.
    // Busy only changes at rising edges, so its value at the falling edge holds
    // for the edge that follows.
    task automatic send_command(input t_cmd cmd, input logic signed [VAL_W-1:0] value,
                                input logic [POS_W-1:0] pos);
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= value;
        i_position <= pos;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        // Track occupancy only to steer delete positions.
        if (cmd == CMD_APPEND && list_len < DEPTH) begin
            list_len++;
        end else if (cmd == CMD_DELETE && pos != 0 && int'(pos) <= list_len) begin
            list_len--;
        end
        if ($urandom_range(99) < idle_pct) begin
            pause_sender($urandom_range(1, 15));
        end
    endtask

    function automatic logic [POS_W-1:0] pick_position(input int valid_pct);
        if (list_len > 0 && $urandom_range(99) < valid_pct) begin
            return POS_W'($urandom_range(1, list_len));
        end
        return POS_W'($urandom_range(0, DEPTH));
    endfunction

    // One random command drawn from the given mix; the rest of the mix is dumps.
    task automatic send_random_command(input int append_pct, input int delete_pct,
                                       input int valid_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < append_pct) begin
            send_command(CMD_APPEND, $urandom, 5'($urandom));
        end else if (roll < append_pct + delete_pct) begin
            send_command(CMD_DELETE, $urandom, pick_position(valid_pct));
        end else begin
            send_command($urandom_range(1) ? CMD_DUMP_BWD : CMD_DUMP_FWD, $urandom,
                         5'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: dumps and deletes report empty.
        send_command(CMD_DUMP_FWD, '0, '0);
        send_command(CMD_DUMP_BWD, '0, '0);
        send_command(CMD_DELETE, '0, 5'd0);
        send_command(CMD_DELETE, '1, 5'd16);

        // Value extremes and alternating bit patterns.
        send_command(CMD_APPEND, 32'sh8000_0000, 5'd31);
        send_command(CMD_APPEND, 32'sh7FFF_FFFF, 5'd0);
        send_command(CMD_APPEND, 32'sh0000_0000, 5'd0);
        send_command(CMD_APPEND, 32'shFFFF_FFFF, 5'd0);
        send_command(CMD_APPEND, 32'sh5555_5555, 5'd0);
        send_command(CMD_APPEND, 32'shAAAA_AAAA, 5'd0);
        send_command(CMD_DUMP_FWD, '0, '0);
        send_command(CMD_DUMP_BWD, '0, '0);

        // Positions of zero and above the count leave the list alone.
        send_command(CMD_DELETE, '0, 5'd0);
        send_command(CMD_DELETE, '0, 5'd7);
        send_command(CMD_DELETE, '0, 5'd16);

        // Delete the last, the first and a middle entry.
        send_command(CMD_DELETE, '0, 5'd6);
        send_command(CMD_DELETE, '0, 5'd1);
        send_command(CMD_DELETE, '0, 5'd2);
        send_command(CMD_DUMP_FWD, '0, '0);
        send_command(CMD_DUMP_BWD, '0, '0);

        // Drain to empty and dump again.
        send_command(CMD_DELETE, '0, 5'd1);
        send_command(CMD_DELETE, '0, 5'd1);
        send_command(CMD_DELETE, '0, 5'd1);
        send_command(CMD_DUMP_FWD, '0, '0);

        // Mixed traffic.
        repeat (20) send_random_command(40, 35, 60);
        // Fill the list until appends are dropped.
        repeat (25) send_random_command(90, 0, 0);
        // Work on a full or nearly full list.
        repeat (15) send_random_command(50, 20, 70);
        // Drain with mostly valid positions.
        repeat (20) send_random_command(10, 75, 85);

        // Last stretch back to back, with no idle cycles.
        idle_pct = 0;
        repeat (10) send_random_command(40, 30, 70);

        start <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("ordered_list_append_delete_unit: match");
        end else begin
            $display("ordered_list_append_delete_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
